@@ rtl/vca_pkg.sv @@
`timescale 1ns / 1ps

package vca_pkg;

  localparam int VOICES    = 32;
  localparam int VOICE_W   = $clog2(VOICES);
  localparam int ENTITY_W  = 10;
  localparam int SUBCH_W   = 8;
  localparam int LENGTH_W  = 24;
  localparam int ADVANCE_W = 16;
  localparam int INDEX_W   = 5;
  localparam int TIME_W    = 32;

  localparam logic [TIME_W-1:0] LIFE_LIMIT = 32'h7FFF_FFFF;
  localparam logic [TIME_W-1:0] SIGN_BIAS  = 32'h8000_0000;
  localparam logic [ENTITY_W-1:0] PLAYER_RESET = 10'd1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_FREE    = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [ENTITY_W-1:0]  entity;
    logic [SUBCH_W-1:0]   sub_channel;
    logic [LENGTH_W-1:0]  sound_length;
    logic [ADVANCE_W-1:0] advance_samples;
    logic [INDEX_W-1:0]   voice_index;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic [INDEX_W-1:0] chosen_voice;
    logic               same_source_override;
  } rsp_t;

  typedef struct packed {
    logic [ENTITY_W-1:0] owner;
    logic [SUBCH_W-1:0]  subchan;
    logic [TIME_W-1:0]   end_time;
  } voice_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic req_alloc;
    logic last_issue;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/vca_ctrl.sv @@
`timescale 1ns / 1ps

module vca_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  vca_pkg::sts_t sts,
  output vca_pkg::cmd_t cmd
);

  vca_pkg::state_t state;
  vca_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vca_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      vca_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && sts.req_alloc) begin
          state_next = vca_pkg::ST_SCAN;
        end
      end
      vca_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) begin
          state_next = vca_pkg::ST_FINISH;
        end
      end
      vca_pkg::ST_FINISH: begin
        state_next = vca_pkg::ST_WRITE;
      end
      vca_pkg::ST_WRITE: begin
        if (!sts.out_busy) begin
          cmd.load   = 1'b1;
          state_next = vca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = vca_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/vca_datapath.sv @@
`timescale 1ns / 1ps

module vca_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  vca_pkg::req_t                  in_data,
  input  logic                           cfg_wr_en,
  input  logic [vca_pkg::ENTITY_W-1:0]   cfg_wr_data,
  input  vca_pkg::cmd_t                  cmd,
  output vca_pkg::sts_t                  sts,
  output logic                           out_valid,
  input  logic                           out_stall,
  output vca_pkg::rsp_t                  out_data
);

  vca_pkg::voice_t mem [vca_pkg::VOICES];
  logic [vca_pkg::VOICES-1:0]   active;

  logic [vca_pkg::TIME_W-1:0]   now_time;
  logic [vca_pkg::ENTITY_W-1:0] player;
  vca_pkg::req_t                req;

  logic [vca_pkg::VOICE_W-1:0]  addr;
  logic                         rd_vld;
  logic [vca_pkg::VOICE_W-1:0]  rd_idx;
  vca_pkg::voice_t              rd_voice;
  logic                         rd_active;

  logic [vca_pkg::TIME_W-1:0]   best;
  logic [vca_pkg::VOICE_W-1:0]  pick;
  logic                         found;
  logic                         same;

  logic                         match;
  logic                         protect;
  logic [vca_pkg::TIME_W-1:0]   life;
  logic [vca_pkg::TIME_W-1:0]   new_end;

  assign sts.req_alloc  = (in_data.opcode == vca_pkg::OP_ALLOC);
  assign sts.last_issue = (addr == vca_pkg::VOICE_W'(vca_pkg::VOICES - 1));
  assign sts.out_busy   = out_valid && out_stall;

  assign match   = (req.sub_channel != '0) && (rd_voice.owner == req.entity)
                   && (rd_voice.subchan == req.sub_channel);
  assign protect = (rd_voice.owner == player) && (req.entity != player) && rd_active;
  assign life    = (rd_voice.end_time - now_time) ^ vca_pkg::SIGN_BIAS;
  assign new_end = now_time + vca_pkg::TIME_W'(req.sound_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      player <= vca_pkg::PLAYER_RESET;
    end else if (cfg_wr_en) begin
      player <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_time <= '0;
    end else if (cmd.accept && in_data.opcode == vca_pkg::OP_ADVANCE) begin
      now_time <= now_time + vca_pkg::TIME_W'(in_data.advance_samples);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd.accept && in_data.opcode == vca_pkg::OP_FREE) begin
      if (32'(in_data.voice_index) < vca_pkg::VOICES) begin
        active[vca_pkg::VOICE_W'(in_data.voice_index)] <= 1'b0;
      end
    end else if (cmd.load && found) begin
      active[pick] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && found) begin
      mem[pick] <= '{owner: req.entity, subchan: req.sub_channel, end_time: new_end};
    end
    rd_voice <= active[addr] ? mem[addr] : '0;
  end

  always_ff @(posedge clk) begin
    rd_active <= active[addr];
    rd_idx    <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
      if (cmd.accept) begin
        addr <= '0;
      end else if (cmd.issue) begin
        addr <= addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      same  <= 1'b0;
    end else if (cmd.accept) begin
      found <= 1'b0;
      same  <= 1'b0;
    end else if (rd_vld && !same) begin
      if (match) begin
        found <= 1'b1;
        same  <= 1'b1;
      end else if (!protect && life < best) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      best <= vca_pkg::LIFE_LIMIT ^ vca_pkg::SIGN_BIAS;
      pick <= '0;
    end else if (rd_vld && !same) begin
      if (match) begin
        pick <= rd_idx;
      end else if (!protect && life < best) begin
        best <= life;
        pick <= rd_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.granted              <= found;
      out_data.chosen_voice         <= found ? vca_pkg::INDEX_W'(pick) : '0;
      out_data.same_source_override <= found && same;
    end
  end

endmodule

@@ rtl/voice_channel_allocator.sv @@
`timescale 1ns / 1ps

// Voice-stealing allocator for a table of mixer voices.
// Input channel (in_valid/in_stall/in_data) carries one request per beat:
// allocate, advance time, or free one voice. Output channel
// (out_valid/out_stall/out_data) returns one beat per allocate request and
// nothing for the other opcodes.
// cfg_wr_en/cfg_wr_data write the player entity; write only while idle.
// Advance and free complete at the accepting edge; the next beat can be
// taken in the following cycle.
// Allocate scans the voice table one entry per cycle through a registered
// memory read, stepping through accept, scan, drain and write-back; the
// input stalls until write-back completes, so no new request is taken
// while an allocate is still in progress.
// A finished result sits in the output register; a new request is accepted
// while it waits. If the receiver still stalls when the next allocate
// finishes its scan, that allocate holds in write-back until the register
// frees.
// Synchronous reset clears all voices (inactive, reading as zero), time
// and pending results, and sets the player entity to 1.
module voice_channel_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  vca_pkg::req_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output vca_pkg::rsp_t                out_data,
  input  logic                         cfg_wr_en,
  input  logic [vca_pkg::ENTITY_W-1:0] cfg_wr_data
);

  vca_pkg::cmd_t cmd;
  vca_pkg::sts_t sts;

  vca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vca_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
